// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is low
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition that must never be seen on a clock edge
`define ASSERT_NEVER(name, cond, msg) \
  `ASSERT_CLK(name, !(cond), msg)

`endif

// ===== rtl/scrl_pkg.sv =====
// shared types and constants of the column to run-length encoder
package scrl_pkg;

  localparam int unsigned ROW_W   = 16;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned RUN_W   = 24;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 128;

  // largest row count and run counter modulus
  localparam longint unsigned ROWS_MAX = 65536;
  localparam longint unsigned RUNS_MAX = 16777216;

  localparam logic [LEN_W-1:0] ROW_LIMIT = LEN_W'(ROWS_MAX);
  localparam logic [RUN_W-1:0] RUN_WRAP  = RUN_W'(RUNS_MAX - 1);

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // one input item after classification
  typedef struct packed {
    logic             empty_col;   // whole column is one zero run
    logic             fresh;       // first run of this item opens a column
    logic             gap_valid;   // zero run before the nonzero
    logic [ROW_W-1:0] gap_start;
    logic [LEN_W-1:0] gap_len;
    logic [ROW_W-1:0] row;
    logic [VAL_W-1:0] value;
    logic             trail_valid; // zero run after the last nonzero
    logic [LEN_W-1:0] trail_len;   // also the column length of an empty column
  } run_desc_t;

endpackage

// ===== rtl/scrl_front.sv =====
// front end: takes input items, tracks the column position and classifies runs
module scrl_front import scrl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             action_i,
  input  logic [ROW_W-1:0] row_i,
  input  logic [VAL_W-1:0] value_i,
  input  logic             last_col_i,
  input  logic [LEN_W-1:0] nrow_i,
  input  logic             queue_full_i,
  output logic             in_ready_o,
  output logic             push_o,
  output run_desc_t        desc_o
);

  logic [ROW_W-1:0] prev_row_q, prev_row_d;
  logic             have_prev_q, have_prev_d;
  logic             fresh_q, fresh_d;

  logic [LEN_W-1:0] row_ext;
  logic [LEN_W-1:0] prev_plus1;
  logic [LEN_W-1:0] row_plus1;
  logic             accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign push_o     = accept;

  assign row_ext    = {1'b0, row_i};
  assign prev_plus1 = {1'b0, prev_row_q} + LEN_W'(1);
  assign row_plus1  = row_ext + LEN_W'(1);

  always_comb begin
    desc_o             = '0;
    desc_o.row         = row_i;
    desc_o.value       = value_i;
    prev_row_d         = prev_row_q;
    have_prev_d        = have_prev_q;
    fresh_d            = fresh_q;
    if (action_i) begin
      desc_o.empty_col = 1'b1;
      desc_o.fresh     = 1'b1;
      desc_o.trail_len = nrow_i;
      have_prev_d      = 1'b0;
      fresh_d          = 1'b1;
    end else begin
      desc_o.fresh = fresh_q;
      if (!have_prev_q) begin
        desc_o.gap_valid = (row_i != '0);
        desc_o.gap_start = '0;
        desc_o.gap_len   = row_ext;
      end else begin
        desc_o.gap_valid = (row_ext > prev_plus1);
        desc_o.gap_start = prev_plus1[ROW_W-1:0];
        desc_o.gap_len   = row_ext - prev_plus1;
      end
      desc_o.trail_valid = last_col_i && (row_plus1 < nrow_i);
      desc_o.trail_len   = nrow_i - row_plus1;
      if (last_col_i) begin
        have_prev_d = 1'b0;
        prev_row_d  = '0;
        fresh_d     = 1'b1;
      end else begin
        have_prev_d = 1'b1;
        prev_row_d  = row_i;
        fresh_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_row_q  <= '0;
      have_prev_q <= 1'b0;
      fresh_q     <= 1'b1;
    end else if (accept) begin
      prev_row_q  <= prev_row_d;
      have_prev_q <= have_prev_d;
      fresh_q     <= fresh_d;
    end
  end

endmodule

// ===== rtl/scrl_queue.sv =====
// short queue of classified items between front and back
`include "assert_macros.svh"
module scrl_queue import scrl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  run_desc_t desc_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      nonempty_o,
  output run_desc_t desc_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  run_desc_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o     = (count_q == CNT_FULL);
  assign nonempty_o = (count_q != '0);
  assign desc_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  `ASSERT_NEVER(a_no_push_full, push_i && full_o, "queue written while full")
  `ASSERT_NEVER(a_no_pop_empty, pop_i && !nonempty_o, "queue read while empty")

endmodule

// ===== rtl/scrl_back.sv =====
// back end: walks each queued item through its runs and numbers them
`include "assert_macros.svh"
module scrl_back import scrl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             nonempty_i,
  input  run_desc_t        desc_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [VAL_W-1:0] run_value_o,
  output logic [LEN_W-1:0] run_length_o,
  output logic [ROW_W-1:0] run_start_o,
  output logic [RUN_W-1:0] run_number_o,
  output logic             column_first_o,
  output logic             last_o
);

  typedef enum logic [1:0] {PH_HEAD, PH_NZ, PH_TRAIL} phase_e;

  phase_e           phase_q, phase_d;
  logic [RUN_W-1:0] counter_q;
  logic             valid_q;
  logic [VAL_W-1:0] value_q, value_d;
  logic [LEN_W-1:0] length_q, length_d;
  logic [ROW_W-1:0] start_q, start_d;
  logic [RUN_W-1:0] number_q;
  logic             first_q, first_d;
  logic             last_q, last_d;
  logic             emit_ok;
  logic             advance;
  logic             fire;

  assign advance = !valid_q || out_ready_i;
  assign fire    = advance && nonempty_i && emit_ok;
  assign pop_o   = fire && last_d;

  always_comb begin
    emit_ok  = 1'b1;
    phase_d  = PH_HEAD;
    value_d  = '0;
    length_d = LEN_W'(1);
    start_d  = desc_i.row;
    first_d  = 1'b0;
    last_d   = 1'b0;
    case (phase_q)
      PH_HEAD: begin
        if (desc_i.empty_col) begin
          length_d = desc_i.trail_len;
          start_d  = '0;
          first_d  = 1'b1;
          last_d   = 1'b1;
        end else if (desc_i.gap_valid) begin
          length_d = desc_i.gap_len;
          start_d  = desc_i.gap_start;
          first_d  = desc_i.fresh;
          phase_d  = PH_NZ;
        end else begin
          value_d  = desc_i.value;
          first_d  = desc_i.fresh;
          last_d   = !desc_i.trail_valid;
          phase_d  = desc_i.trail_valid ? PH_TRAIL : PH_HEAD;
        end
      end
      PH_NZ: begin
        value_d = desc_i.value;
        last_d  = !desc_i.trail_valid;
        phase_d = desc_i.trail_valid ? PH_TRAIL : PH_HEAD;
      end
      PH_TRAIL: begin
        length_d = desc_i.trail_len;
        start_d  = desc_i.row + ROW_W'(1);
        last_d   = 1'b1;
      end
      default: begin
        emit_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEAD;
      counter_q <= '0;
      valid_q   <= 1'b0;
      value_q   <= '0;
      length_q  <= '0;
      start_q   <= '0;
      number_q  <= '0;
      first_q   <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      if (!emit_ok) begin
        phase_q <= PH_HEAD;
      end
      if (advance) begin
        valid_q <= fire;
      end
      if (fire) begin
        phase_q   <= phase_d;
        value_q   <= value_d;
        length_q  <= length_d;
        start_q   <= start_d;
        number_q  <= counter_q;
        first_q   <= first_d;
        last_q    <= last_d;
        counter_q <= (counter_q == RUN_WRAP) ? '0 : counter_q + RUN_W'(1);
      end
    end
  end

  assign out_valid_o    = valid_q;
  assign run_value_o    = value_q;
  assign run_length_o   = length_q;
  assign run_start_o    = start_q;
  assign run_number_o   = number_q;
  assign column_first_o = first_q;
  assign last_o         = last_q;

  `ASSERT_CLK(a_len_nonzero, valid_q |-> (length_q != '0), "run of zero length")
  `ASSERT_CLK(a_mid_item_held, (phase_q != PH_HEAD) |-> nonempty_i,
              "item left the queue before its last run")

endmodule

// ===== rtl/sparse_column_to_run_length_top.sv =====
// top level of the compressed sparse column to run-length encoder
// Converts a compressed-sparse-column matrix, fed one nonzero (or one empty
// column marker) per transfer, into runs that cover every row of each column.
// Each nonzero gives a run of length one carrying its value; zero rows before
// it, between nonzeros and after the column's last nonzero give zero runs,
// and an empty column gives one zero run over all rows. Runs carry a running
// number, and the first run of a column is flagged in tuser so its number is
// the column's start offset. A front stage takes one item per cycle while the
// queue has room and classifies it into up to three runs, a two-entry queue
// decouples it from the back stage, and the back stage emits one run per
// cycle into an output register while the output is taken. An item yields
// one to three runs, three in the worst case of a gap, a nonzero and a
// trailing zero run. Input is still taken while results wait, until the
// queue fills. The user must write the row count through the cfg channel only
// while the block is idle; the block does not enforce this. 0 acts as 1 and
// values above 65536 act as 65536. Row indices must rise within a column.
module sparse_column_to_run_length_top import scrl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // row count register write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [LEN_W-1:0]      cfg_data_i,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // row_index[15:0], element_value[79:16]
  input  logic                  s_axis_tuser,  // action (1 = empty column)
  input  logic                  s_axis_tlast,  // last_in_column
  // result runs
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // run_value[63:0], run_length[80:64],
                                               // run_start[96:81], run_number[120:97],
                                               // zero [127:121]
  output logic                  m_axis_tuser,  // column_first
  output logic                  m_axis_tlast   // last run of this input item
);

  logic [LEN_W-1:0] row_count_q;
  logic [LEN_W-1:0] nrow;

  logic      push;
  logic      queue_full;
  logic      queue_nonempty;
  logic      pop;
  run_desc_t push_desc;
  run_desc_t head_desc;

  logic [VAL_W-1:0] run_value;
  logic [LEN_W-1:0] run_length;
  logic [ROW_W-1:0] run_start;
  logic [RUN_W-1:0] run_number;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= LEN_W'(1);
    end else if (cfg_valid_i) begin
      row_count_q <= cfg_data_i;
    end
  end

  // clamp the row count into 1..ROWS_MAX
  always_comb begin
    if (row_count_q == '0) begin
      nrow = LEN_W'(1);
    end else if (row_count_q > ROW_LIMIT) begin
      nrow = ROW_LIMIT;
    end else begin
      nrow = row_count_q;
    end
  end

  scrl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .action_i     (s_axis_tuser),
    .row_i        (s_axis_tdata[ROW_W-1:0]),
    .value_i      (s_axis_tdata[ROW_W+VAL_W-1:ROW_W]),
    .last_col_i   (s_axis_tlast),
    .nrow_i       (nrow),
    .queue_full_i (queue_full),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .desc_o       (push_desc)
  );

  scrl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .desc_i     (push_desc),
    .pop_i      (pop),
    .full_o     (queue_full),
    .nonempty_o (queue_nonempty),
    .desc_o     (head_desc)
  );

  scrl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .nonempty_i     (queue_nonempty),
    .desc_i         (head_desc),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .run_value_o    (run_value),
    .run_length_o   (run_length),
    .run_start_o    (run_start),
    .run_number_o   (run_number),
    .column_first_o (m_axis_tuser),
    .last_o         (m_axis_tlast)
  );

  // pack the run fields from the lowest bit up, zero fill to whole bytes
  assign m_axis_tdata = {
    (OUT_DATA_W - VAL_W - LEN_W - ROW_W - RUN_W)'(0),
    run_number, run_start, run_length, run_value
  };

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the sparse column to run-length encoder
`timescale 1ns / 100ps

// expected runs of the encoder, worked out item by item, and their check
class run_scoreboard;
  typedef struct {
    logic [scrl_pkg::VAL_W-1:0] value;
    logic [scrl_pkg::LEN_W-1:0] length;
    logic [scrl_pkg::ROW_W-1:0] start;
    logic [scrl_pkg::RUN_W-1:0] number;
    bit                         first;
    bit                         last;
  } run_t;

  run_t runs_due[$];
  int unsigned mismatches = 0;

  // encoder state as seen from outside
  logic [scrl_pkg::LEN_W-1:0] row_count = 1;
  logic [scrl_pkg::ROW_W-1:0] prev_row = 0;
  bit                         have_prev = 0;
  logic [scrl_pkg::RUN_W-1:0] run_ctr = 0;
  bit                         col_fresh = 1;

  function void set_row_count(logic [scrl_pkg::LEN_W-1:0] count);
    row_count = count;
  endfunction

  // row count after clamping to 1..65536
  function int unsigned rows_in_use();
    int unsigned n;
    n = 32'(row_count);
    if (n == 0) n = 1;
    if (n > scrl_pkg::ROWS_MAX) n = 32'(scrl_pkg::ROWS_MAX);
    return n;
  endfunction

  function void add_run(logic [scrl_pkg::VAL_W-1:0] value, int unsigned length,
                        int unsigned start);
    run_t r;
    r.value  = value;
    r.length = scrl_pkg::LEN_W'(length);
    r.start  = scrl_pkg::ROW_W'(start);
    r.number = run_ctr;
    r.first  = col_fresh;
    r.last   = 0;
    runs_due.push_back(r);
    col_fresh = 0;
    run_ctr++;  // wraps at 2^24
  endfunction

  // runs caused by one accepted item
  function void expand_item(bit empty_col, logic [scrl_pkg::ROW_W-1:0] row,
                            logic [scrl_pkg::VAL_W-1:0] value, bit last_col);
    int unsigned nrow;
    int unsigned r;
    int unsigned prev;
    run_t tail;
    nrow = rows_in_use();
    r = 32'(row);
    prev = 32'(prev_row);
    if (empty_col) begin
      // open column is dropped without a trailing run
      col_fresh = 1;
      have_prev = 0;
      add_run('0, nrow, 0);
      col_fresh = 1;
    end else begin
      if (!have_prev) begin
        if (r > 0) add_run('0, r, 0);
      end else if (r > prev + 1) begin
        add_run('0, r - prev - 1, prev + 1);
      end
      add_run(value, 1, r);
      if (last_col) begin
        if (r + 1 < nrow) add_run('0, nrow - r - 1, r + 1);
        have_prev = 0;
        prev_row  = 0;
        col_fresh = 1;
      end else begin
        have_prev = 1;
        prev_row  = row;
      end
    end
    tail = runs_due.pop_back();
    tail.last = 1;
    runs_due.push_back(tail);
  endfunction

  function void check_run(logic [scrl_pkg::OUT_DATA_W-1:0] data, logic first,
                          logic last);
    run_t e;
    bit bad;
    if (runs_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected run: data %h first %b last %b", data, first, last);
      return;
    end
    e = runs_due.pop_front();
    bad = (data[63:0] !== e.value) || (data[80:64] !== e.length) ||
          (data[96:81] !== e.start) || (data[120:97] !== e.number) ||
          (data[127:121] !== '0) || (first !== e.first) || (last !== e.last);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("run mismatch: expected value %h len %0d start %0d num %0d first %b last %b",
                 e.value, e.length, e.start, e.number, e.first, e.last);
        $display("  actual value %h len %0d start %0d num %0d first %b last %b pad %h",
                 data[63:0], data[80:64], data[96:81], data[120:97], first, last,
                 data[127:121]);
      end
    end
  endfunction
endclass

module tb;
  import scrl_pkg::*;

  localparam bit ACT_NONZERO   = 1'b0;
  localparam bit ACT_EMPTY_COL = 1'b1;
  localparam int CYCLE_LIMIT   = 300000;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  cfg_valid_i = 0;
  logic                  cfg_ready_o;
  logic [LEN_W-1:0]      cfg_data_i = '0;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // row_index, element_value
  logic                  s_axis_tuser = 0;   // action
  logic                  s_axis_tlast = 0;   // last_in_column
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // run_value, run_length, run_start, run_number
  logic                  m_axis_tuser;       // column_first
  logic                  m_axis_tlast;       // last run of the item

  run_scoreboard sb = new;
  int send_idle = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int cycles = 0;

  sparse_column_to_run_length_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_run(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_row_count(logic [LEN_W-1:0] count);
    cfg_data_i  <= count;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_row_count(count);
  endtask

  // valid stays high across back-to-back items, it only drops for a gap
  task automatic send_item(bit empty_col, logic [ROW_W-1:0] row, logic [VAL_W-1:0] value,
                           bit last_col);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {value, row};
    s_axis_tuser  <= empty_col;
    s_axis_tlast  <= last_col;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.expand_item(empty_col, row, value, last_col);
    items_sent++;
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  // one well-formed column: up to three rising rows below the row count
  task automatic send_column();
    int unsigned nrow, k, lo, hi, r;
    nrow = sb.rows_in_use();
    k = $urandom_range(3);
    if (k > nrow) k = nrow;
    if (k == 0) begin
      send_item(ACT_EMPTY_COL, ROW_W'($urandom), rand_value(), 1'($urandom_range(1)));
    end else begin
      lo = 0;
      for (int unsigned i = 0; i < k; i++) begin
        hi = nrow - k + i;
        case ($urandom_range(3))
          0:       r = lo;
          1:       r = hi;
          default: r = $urandom_range(hi, lo);
        endcase
        send_item(ACT_NONZERO, ROW_W'(r), rand_value(), i == k - 1);
        lo = r + 1;
      end
    end
  endtask

  // lets every expected run arrive, then idles as slack
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.runs_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    logic [LEN_W-1:0] counts[8];
    int target;
    counts = '{17'd1, 17'd0, 17'd65536, 17'd131071, 17'd5, 17'd65537, 17'd16,
               LEN_W'($urandom_range(65536, 2))};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, eight rows per column
    write_row_count(17'd8);
    send_item(ACT_NONZERO, 16'd0, '0, 1'b0);              // no leading zeros
    send_item(ACT_NONZERO, 16'd1, '1, 1'b0);              // adjacent row
    send_item(ACT_NONZERO, 16'd4, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);  // gap and trailer
    send_item(ACT_EMPTY_COL, 16'hffff, '1, 1'b1);         // unused fields set
    send_item(ACT_EMPTY_COL, 16'd0, '0, 1'b0);
    send_item(ACT_NONZERO, 16'd3, 64'h5555_5555_5555_5555, 1'b1);  // leading zeros
    send_item(ACT_NONZERO, 16'd7, rand_value(), 1'b1);    // last row, no trailer
    send_item(ACT_NONZERO, 16'd5, rand_value(), 1'b0);
    send_item(ACT_NONZERO, 16'd5, rand_value(), 1'b0);    // repeated row
    send_item(ACT_NONZERO, 16'd2, rand_value(), 1'b1);    // falling row
    send_item(ACT_NONZERO, 16'd2, rand_value(), 1'b0);
    send_item(ACT_EMPTY_COL, 16'd6, rand_value(), 1'b0);  // empty column drops open one
    send_item(ACT_NONZERO, 16'hffff, '1, 1'b1);           // row far past the count
    send_item(ACT_NONZERO, 16'd10, rand_value(), 1'b0);
    send_item(ACT_NONZERO, 16'd12, rand_value(), 1'b1);   // gap past the count
    send_item(ACT_NONZERO, 16'd0, rand_value(), 1'b1);    // lone row 0, full trailer
    send_item(ACT_NONZERO, 16'd8, rand_value(), 1'b1);    // row equal to the count
    send_item(ACT_NONZERO, 16'd6, rand_value(), 1'b0);
    send_item(ACT_NONZERO, 16'd7, rand_value(), 1'b1);
    drain();

    // random part: several row counts, each under one idling mix
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 47; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 47; end
        default: begin send_idle = 37; stall_pct = 37; end
      endcase
      write_row_count(counts[p]);
      target = items_sent + 13;
      while (items_sent < target) begin
        if ($urandom_range(99) < 15)
          send_item($urandom_range(3) == 0, ROW_W'($urandom), rand_value(),
                    1'($urandom_range(1)));
        else
          send_column();
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.runs_due.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/scrl_pkg.sv
rtl/scrl_front.sv
rtl/scrl_queue.sv
rtl/scrl_back.sv
rtl/sparse_column_to_run_length_top.sv
bench/tb.sv
